// File: rtl/core/poly_voice_synth_defines.svh
// Assertion macros used by poly_voice_synth.sv.
`ifndef POLY_VOICE_SYNTH_DEFINES_SVH
`define POLY_VOICE_SYNTH_DEFINES_SVH

`define PVS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define PVS_ASSERT_NEXT(name, cond, rslt, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (rslt)) else $error(msg);

`endif

// File: rtl/core/pvs_pkg.sv
`timescale 1ns / 1ps
package pvs_pkg;

  localparam int VOICES_DEF    = 16;
  localparam int SINE_BITS_DEF = 10;

  localparam int CMD_W  = 2;
  localparam int NOTE_W = 7;
  localparam int VEL_W  = 16;
  localparam int IR_W   = 21;
  localparam int OUT_W  = 23;
  localparam int ENV_W  = 17;
  localparam int PH_W   = 32;
  localparam int FREQ_W = 30;
  localparam int AMP_W  = 14;
  localparam int WAVE_W = 34;
  localparam int ADDR_W = 2;

  localparam int MA_W = 35;
  localparam int MB_W = 18;
  localparam int MP_W = MA_W + MB_W;

  localparam logic [CMD_W-1:0] CMD_ON   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OFF  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

  localparam logic [ADDR_W-1:0] ADDR_INV_RATE = 2'd0;

  localparam logic [IR_W-1:0]  IR_RESET     = 21'd89478;
  localparam logic [ENV_W-1:0] ENV_ONE      = 17'd65536;
  localparam logic [ENV_W-1:0] ATTACK_STEP  = 17'd131;
  localparam logic [ENV_W-1:0] SKIP_LEVEL   = 17'd66;
  localparam logic [ENV_W-1:0] SILENT_LEVEL = 17'd7;

  localparam logic signed [MB_W-1:0] RELEASE_MUL = 18'sd65503;
  localparam logic signed [MB_W-1:0] SAW_GAIN    = 18'sd39322;
  localparam logic signed [MB_W-1:0] SINE_GAIN   = 18'sd26214;
  localparam logic signed [MB_W-1:0] OUT_GAIN    = 18'sd9830;

  localparam int OUT_MAX = 4194303;
  localparam int OUT_MIN = -4194304;

  localparam logic [63:0] C_A1 = 64'd1686629713;
  localparam logic [63:0] C_B3 = 64'd693598669;
  localparam logic [63:0] C_B5 = 64'd85569304;
  localparam logic [63:0] C_B7 = 64'd5026995;
  localparam logic [63:0] C_B9 = 64'd172272;

  localparam logic [31:0] TOP_OCT [12] = '{
    32'd548668578, 32'd581294109, 32'd615859655, 32'd652480576,
    32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
    32'd870957065, 32'd922746880, 32'd977616237, 32'd1035748353
  };

  typedef logic [FREQ_W-1:0] freq_tab_t [128];

  function automatic freq_tab_t build_freq();
    freq_tab_t t;
    int oct;
    int semi;
    int sh;
    for (int n = 0; n < 128; n++) begin
      oct  = n / 12;
      semi = n % 12;
      sh   = 10 - oct;
      t[n] = FREQ_W'((64'(TOP_OCT[semi]) + ((64'd1 << sh) >> 1)) >> sh);
    end
    return t;
  endfunction

  localparam freq_tab_t FREQ_TAB = build_freq();

  function automatic logic [ENV_W-1:0] quarter_sine(input int k, input int qb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    x  = 64'(k) << (30 - qb);
    x2 = (x * x) >> 30;
    p  = C_B7 - ((x2 * C_B9) >> 30);
    p  = C_B5 - ((x2 * p) >> 30);
    p  = C_B3 - ((x2 * p) >> 30);
    p  = C_A1 - ((x2 * p) >> 30);
    return ENV_W'((p * x + (64'd1 << 43)) >> 44);
  endfunction

  typedef enum logic [4:0] {
    ST_IDLE, ST_NRD, ST_NCMP, ST_NWR, ST_FRD, ST_FCMP,
    ST_TRD, ST_TENV, ST_TREL, ST_TCHK, ST_TM1, ST_TM2, ST_TM3, ST_TM4,
    ST_TM5, ST_TM6, ST_TM7, ST_TM8, ST_TNEXT, ST_TOUT
  } st_t;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic [PH_W-1:0]   phase;
    logic [ENV_W-1:0]  env;
  } voice_t;

  typedef struct packed {
    logic   en;
    voice_t data;
  } vram_wr_t;

endpackage

// File: rtl/core/pvs_mul.sv
`timescale 1ns / 1ps
module pvs_mul (
  input  logic                               clk,
  input  logic signed [pvs_pkg::MA_W-1:0]    a,
  input  logic signed [pvs_pkg::MB_W-1:0]    b,
  output logic signed [pvs_pkg::MP_W-1:0]    p
);
  import pvs_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// File: rtl/core/pvs_sine_rom.sv
`timescale 1ns / 1ps
module pvs_sine_rom #(
  parameter int SINE_TABLE_BITS = pvs_pkg::SINE_BITS_DEF
) (
  input  logic                             clk,
  input  logic [SINE_TABLE_BITS-1:0]       idx,
  output logic signed [pvs_pkg::MB_W-1:0]  data
);
  import pvs_pkg::*;

  localparam int QB = SINE_TABLE_BITS - 2;
  localparam int QN = 1 << QB;

  typedef logic [ENV_W-1:0] qtab_t [QN+1];

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int k = 0; k <= QN; k++) begin
      t[k] = quarter_sine(k, QB);
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  logic [1:0]    quad;
  logic [QB-1:0] r;
  logic [QB:0]   k;

  assign quad = idx[SINE_TABLE_BITS-1 -: 2];
  assign r    = idx[QB-1:0];
  assign k    = quad[0] ? ((QB+1)'(QN) - {1'b0, r}) : {1'b0, r};

  always_ff @(posedge clk) begin
    if (quad[1]) begin
      data <= -$signed({1'b0, QTAB[k]});
    end else begin
      data <= $signed({1'b0, QTAB[k]});
    end
  end

endmodule

// File: rtl/core/pvs_voice_ram.sv
`timescale 1ns / 1ps
module pvs_voice_ram #(
  parameter int VOICES = pvs_pkg::VOICES_DEF,
  parameter int VW     = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [VW-1:0]       raddr,
  output pvs_pkg::voice_t     rdata,
  input  logic [VW-1:0]       waddr,
  input  pvs_pkg::vram_wr_t   wr
);
  import pvs_pkg::*;

  voice_t            mem [VOICES];
  logic [VOICES-1:0] valid;
  voice_t            rd_q;
  logic              vld_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[waddr] <= wr.data;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[waddr] <= 1'b1;
      end
      vld_q <= valid[raddr];
    end
  end

  assign rdata = vld_q ? rd_q : '0;

endmodule

// File: rtl/core/poly_voice_synth.sv
`timescale 1ns / 1ps
// Note on: writes a free voice directly, else first scans all voices for the quietest one.
// Note off: scans every voice. Tick: steps through each voice in turn, one sample out.
// Work is serialised by the single shared multiplier and the one-read-port voice memory.
// One command is in flight at a time; the next is taken while a sample waits at the output.
// Synchronous reset clears all voices and the output valid flag and sets inv_rate to 89478.
`include "poly_voice_synth_defines.svh"
module poly_voice_synth #(
  parameter int VOICES          = pvs_pkg::VOICES_DEF,
  parameter int SINE_TABLE_BITS = pvs_pkg::SINE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pvs_pkg::ADDR_W-1:0]           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [pvs_pkg::CMD_W-1:0]            cmd,
  input  logic [pvs_pkg::NOTE_W-1:0]           note_number,
  input  logic [pvs_pkg::VEL_W-1:0]            velocity,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pvs_pkg::OUT_W-1:0]     sample_out
);
  import pvs_pkg::*;

  localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SUM_W = OUT_W + $clog2(VOICES) + 1;
  localparam logic [VW-1:0] LAST = VW'(VOICES - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(OUT_MAX);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(OUT_MIN);

  st_t state;
  st_t state_next;

  logic [IR_W-1:0]          inv_rate;
  logic [VOICES-1:0]        active;
  logic [VW-1:0]            vidx;
  logic [VW-1:0]            slot;
  logic [VW-1:0]            first_free;
  logic [ENV_W-1:0]         best;
  logic [NOTE_W-1:0]        cmd_note;
  logic [VEL_W-1:0]         cmd_vel;
  logic [ENV_W-1:0]         env_r;
  logic [ENV_W:0]           env_add;
  logic [PH_W-1:0]          phase_r;
  logic [PH_W-1:0]          step_r;
  logic [51:0]              acc;
  logic [51:0]              step_sum;
  logic signed [WAVE_W-1:0] part;
  logic signed [WAVE_W-1:0] wave_r;
  logic [AMP_W-1:0]         amp_r;
  logic signed [SUM_W-1:0]  sum;
  logic signed [MP_W-1:0]   prod_sh;
  logic [FREQ_W-1:0]        freq;
  logic signed [MB_W-1:0]   saw;
  logic signed [MB_W-1:0]   sine;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [MP_W-1:0]   prod;
  voice_t                   v;
  vram_wr_t                 wr;
  logic [VW-1:0]            waddr;
  logic                     in_acc;
  logic                     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr == ADDR_INV_RATE) ? 32'(inv_rate) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_rate <= IR_RESET;
    end else if (cfg_wr && paddr == ADDR_INV_RATE) begin
      inv_rate <= pwdata[IR_W-1:0];
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    first_free = '0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!active[i]) begin
        first_free = VW'(i);
      end
    end
  end

  pvs_voice_ram #(.VOICES(VOICES), .VW(VW)) u_ram (
    .clk   (clk),
    .rst   (rst),
    .raddr (vidx),
    .rdata (v),
    .waddr (waddr),
    .wr    (wr)
  );

  pvs_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_rom (
    .clk  (clk),
    .idx  (phase_r[PH_W-1 -: SINE_TABLE_BITS]),
    .data (sine)
  );

  pvs_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign freq     = FREQ_TAB[v.note];
  assign saw      = $signed({1'b0, phase_r[PH_W-1:15]}) - 18'sd65536;
  assign env_add  = {1'b0, v.env} + {1'b0, ATTACK_STEP};
  assign step_sum = acc + {prod[40:0], 11'b0};
  assign prod_sh  = prod >>> 28;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_TENV: begin
        mul_a = $signed(MA_W'(v.env));
        mul_b = RELEASE_MUL;
      end
      ST_TCHK: begin
        mul_a = $signed(MA_W'(freq));
        mul_b = $signed(MB_W'(inv_rate[10:0]));
      end
      ST_TM1: begin
        mul_a = $signed(MA_W'(freq));
        mul_b = $signed(MB_W'(inv_rate[IR_W-1:11]));
      end
      ST_TM2: begin
        mul_a = $signed(MA_W'(env_r));
        mul_b = $signed(MB_W'(v.vel));
      end
      ST_TM3: begin
        mul_a = $signed(MA_W'(prod[33:0]));
        mul_b = OUT_GAIN;
      end
      ST_TM4: begin
        mul_a = MA_W'(saw);
        mul_b = SAW_GAIN;
      end
      ST_TM5: begin
        mul_a = MA_W'(sine);
        mul_b = SINE_GAIN;
      end
      ST_TM7: begin
        mul_a = MA_W'(wave_r);
        mul_b = $signed(MB_W'(amp_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    wr.en   = 1'b0;
    wr.data = '0;
    waddr   = vidx;
    unique case (state)
      ST_NWR: begin
        wr.en      = 1'b1;
        wr.data    = '{note: cmd_note, vel: cmd_vel, phase: '0, env: '0};
        waddr      = slot;
      end
      ST_TCHK: begin
        wr.en   = (env_r < SILENT_LEVEL);
        wr.data = '{note: v.note, vel: v.vel, phase: v.phase, env: env_r};
      end
      ST_TM4: begin
        wr.en   = 1'b1;
        wr.data = '{note: v.note, vel: v.vel, phase: phase_r, env: env_r};
      end
      default: begin
        wr.en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd)
            CMD_ON:   state_next = (&active) ? ST_NRD : ST_NWR;
            CMD_OFF:  state_next = ST_FRD;
            CMD_TICK: state_next = ST_TRD;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_NRD:  state_next = ST_NCMP;
      ST_NCMP: state_next = (vidx == LAST) ? ST_NWR : ST_NRD;
      ST_NWR:  state_next = ST_IDLE;
      ST_FRD:  state_next = ST_FCMP;
      ST_FCMP: state_next = (vidx == LAST) ? ST_IDLE : ST_FRD;
      ST_TRD:  state_next = ST_TENV;
      ST_TENV: begin
        if (!active[vidx] && v.env < SKIP_LEVEL) begin
          state_next = ST_TNEXT;
        end else if (active[vidx]) begin
          state_next = ST_TCHK;
        end else begin
          state_next = ST_TREL;
        end
      end
      ST_TREL:  state_next = ST_TCHK;
      ST_TCHK:  state_next = (env_r < SILENT_LEVEL) ? ST_TNEXT : ST_TM1;
      ST_TM1:   state_next = ST_TM2;
      ST_TM2:   state_next = ST_TM3;
      ST_TM3:   state_next = ST_TM4;
      ST_TM4:   state_next = ST_TM5;
      ST_TM5:   state_next = ST_TM6;
      ST_TM6:   state_next = ST_TM7;
      ST_TM7:   state_next = ST_TM8;
      ST_TM8:   state_next = ST_TNEXT;
      ST_TNEXT: state_next = (vidx == LAST) ? ST_TOUT : ST_TRD;
      ST_TOUT:  state_next = (!out_valid || out_ready) ? ST_IDLE : ST_TOUT;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= '0;
      vidx      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_TOUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          vidx <= '0;
        end
        ST_NCMP, ST_TNEXT: begin
          if (vidx != LAST) begin
            vidx <= vidx + 1'b1;
          end
        end
        ST_NWR: begin
          active[slot] <= 1'b1;
        end
        ST_FCMP: begin
          if (active[vidx] && v.note == cmd_note) begin
            active[vidx] <= 1'b0;
          end
          if (vidx != LAST) begin
            vidx <= vidx + 1'b1;
          end
        end
        ST_TOUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
          end
        end
        default: begin
          vidx <= vidx;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cmd_note <= note_number;
        cmd_vel  <= velocity;
        slot     <= first_free;
        best     <= ENV_ONE + 1'b1;
        sum      <= '0;
      end
      ST_NCMP: begin
        if (v.env < best) begin
          best <= v.env;
          slot <= vidx;
        end
      end
      ST_TENV: begin
        env_r <= (env_add > {1'b0, ENV_ONE}) ? ENV_ONE : env_add[ENV_W-1:0];
      end
      ST_TREL: env_r   <= prod[32:16];
      ST_TM1:  acc     <= prod[51:0];
      ST_TM2:  step_r  <= step_sum[47:16];
      ST_TM3:  phase_r <= v.phase + step_r;
      ST_TM4:  amp_r   <= prod[45:32];
      ST_TM5:  part    <= prod[WAVE_W-1:0];
      ST_TM6:  wave_r  <= part + prod[WAVE_W-1:0];
      ST_TM8:  sum     <= sum + $signed(prod_sh[SUM_W-1:0]);
      ST_TOUT: begin
        if (!out_valid || out_ready) begin
          if (sum > SAT_HI) begin
            sample_out <= OUT_W'(SAT_HI);
          end else if (sum < SAT_LO) begin
            sample_out <= OUT_W'(SAT_LO);
          end else begin
            sample_out <= sum[OUT_W-1:0];
          end
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  `PVS_ASSERT_NEXT(a_noteon_sets_active, state == ST_NWR, active[$past(slot)], "note on did not claim its voice")
  `PVS_ASSERT_NEXT(a_tick_starts_at_zero, in_acc && cmd == CMD_TICK, state == ST_TRD && vidx == '0, "tick did not start at voice zero")
  `PVS_ASSERT(a_out_from_tick, $rose(out_valid) |-> $past(state == ST_TOUT), "sample appeared outside a tick")

endmodule

// File: bench/poly_voice_synth_test.sv
`timescale 1ns / 1ps
module poly_voice_synth_test;
  import pvs_pkg::*;

  localparam int NV = 16;
  localparam int SB = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] cmd = '0;
  logic [NOTE_W-1:0] note_number = '0;
  logic [VEL_W-1:0] velocity = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] sample_out;

  poly_voice_synth DUT (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
    .note_number(note_number), .velocity(velocity),
    .out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

  typedef struct {
    logic [CMD_W-1:0] c;
    logic [NOTE_W-1:0] n;
    logic [VEL_W-1:0] v;
    bit fixed;
    logic signed [OUT_W-1:0] want;
  } beat_t;

  int sine_tab [1 << SB];
  logic [20:0] rate_q;
  bit v_on [NV];
  logic [6:0] v_key [NV];
  logic [15:0] v_vel [NV];
  logic [31:0] v_ph [NV];
  logic [16:0] v_env [NV];
  logic signed [OUT_W-1:0] samples_due [$];
  int errors = 0;
  int out_wait = 0;

  function automatic int quarter_wave(input int k);
    logic [63:0] x, x2, p;
    x = 64'(k) << (30 - (SB - 2));
    x2 = (x * x) >> 30;
    p = 64'd5026995 - ((x2 * 64'd172272) >> 30);
    p = 64'd85569304 - ((x2 * p) >> 30);
    p = 64'd693598669 - ((x2 * p) >> 30);
    p = 64'd1686629713 - ((x2 * p) >> 30);
    return int'((p * x + (64'd1 << 43)) >> 44);
  endfunction

  function automatic logic [31:0] phase_inc(input logic [6:0] key);
    logic [31:0] tops [12];
    int sh;
    logic [63:0] f;
    tops = '{32'd548668578, 32'd581294109, 32'd615859655, 32'd652480576,
             32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
             32'd870957065, 32'd922746880, 32'd977616237, 32'd1035748353};
    sh = 10 - key / 12;
    f = (64'(tops[key % 12]) + ((64'd1 << sh) >> 1)) >> sh;
    return 32'((f * 64'(rate_q)) >> 16);
  endfunction

  task automatic clear_voices();
    for (int i = 0; i < NV; i++) begin
      v_on[i] = 0; v_key[i] = 0; v_vel[i] = 0; v_ph[i] = 0; v_env[i] = 0;
    end
  endtask

  task automatic apply_command(input beat_t b);
    int slot, low_i;
    logic [17:0] low_e;
    bit got;
    longint acc, saw, sn, wave, amp, prod;
    logic [16:0] e;
    if (b.c == CMD_ON) begin
      got = 0; slot = 0; low_i = 0; low_e = 18'd65537;
      for (int i = 0; i < NV; i++) begin
        if (!v_on[i]) begin
          slot = i; got = 1; break;
        end
        if (v_env[i] < low_e) begin
          low_e = v_env[i]; low_i = i;
        end
      end
      if (!got) slot = low_i;
      v_on[slot] = 1; v_key[slot] = b.n; v_vel[slot] = b.v;
      v_ph[slot] = 0; v_env[slot] = 0;
    end else if (b.c == CMD_OFF) begin
      for (int i = 0; i < NV; i++)
        if (v_on[i] && v_key[i] == b.n) v_on[i] = 0;
    end else if (b.c == CMD_TICK) begin
      acc = 0;
      for (int i = 0; i < NV; i++) begin
        e = v_env[i];
        if (e < 66 && !v_on[i]) continue;
        if (v_on[i]) e = (e + 131 > 65536) ? 17'd65536 : e + 17'd131;
        else e = 17'((64'(e) * 64'd65503) >> 16);
        v_env[i] = e;
        if (e < 7) continue;
        v_ph[i] = v_ph[i] + phase_inc(v_key[i]);
        saw = longint'(v_ph[i] >> 15) - 65536;
        sn = sine_tab[v_ph[i] >> (32 - SB)];
        wave = saw * 39322 + sn * 26214;
        amp = longint'((64'(e) * 64'(v_vel[i]) * 64'd9830) >> 32);
        prod = wave * amp;
        acc += prod >>> 28;
      end
      if (acc > 4194303) acc = 4194303;
      if (acc < -4194304) acc = -4194304;
      samples_due.push_back(OUT_W'(acc));
    end
  endtask

  task automatic write_rate(input logic [20:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_INV_RATE; pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    rate_q = val;
  endtask

  task automatic send(input beat_t b);
    int gap;
    gap = $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1; cmd <= b.c; note_number <= b.n; velocity <= b.v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_command(b);
    if (b.fixed && samples_due.size() > 0 && samples_due[$] !== b.want) begin
      $display("%0t: table row expected %0d, predictor %0d", $time, b.want,
               samples_due[$]);
      errors++;
    end
  endtask

  task automatic drain_and_wait();
    in_valid <= 1'b0;
    @(posedge clk);
    while (samples_due.size() > 0) @(posedge clk);
    repeat (16 * NV + 50) @(posedge clk);
  endtask

  function automatic beat_t mk(input logic [CMD_W-1:0] c, input int n, input int v);
    beat_t b;
    b.c = c; b.n = 7'(n); b.v = 16'(v); b.fixed = 0; b.want = 0;
    return b;
  endfunction

  function automatic beat_t random_beat();
    int r;
    beat_t b;
    r = $urandom_range(0, 99);
    b = mk(CMD_TICK, $urandom_range(0, 127), $urandom_range(0, 65535));
    if (r < 25) b.c = CMD_ON;
    else if (r < 37) b.c = CMD_OFF;
    else if (r < 39) b.c = CMD_NONE;
    if ($urandom_range(0, 3) == 0) b.n = 7'($urandom_range(55, 70));
    return b;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (samples_due.size() == 0) begin
          $display("%0t: unexpected sample, actual %0d", $time, sample_out);
          errors++;
        end else begin
          if (sample_out !== samples_due[0]) begin
            $display("%0t: sample_out expected %0d, actual %0d", $time,
                     samples_due[0], sample_out);
            errors++;
          end
          void'(samples_due.pop_front());
        end
        out_wait = $urandom_range(0, 14);
      end else if (out_valid && out_wait > 0) begin
        out_wait--;
      end
      out_ready <= (out_wait == 0);
    end
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    beat_t rows [$];
    logic [20:0] rates [4];
    for (int i = 0; i < (1 << SB); i++) begin
      int q, r, vq;
      q = i >> (SB - 2);
      r = i & ((1 << (SB - 2)) - 1);
      vq = quarter_wave((q & 1) ? (1 << (SB - 2)) - r : r);
      sine_tab[i] = (q & 2) ? -vq : vq;
    end
    rate_q = 21'd89478;
    clear_voices();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    rows.push_back(mk(CMD_TICK, 0, 0));
    rows[0].fixed = 1; rows[0].want = 0;
    rows.push_back(mk(CMD_ON, 127, 65535));
    rows.push_back(mk(CMD_TICK, 0, 0));
    rows.push_back(mk(CMD_ON, 0, 0));
    rows.push_back(mk(CMD_ON, 69, 1));
    rows.push_back(mk(CMD_NONE, 69, 65535));
    rows.push_back(mk(CMD_TICK, 0, 0));
    rows.push_back(mk(CMD_OFF, 127, 12345));
    rows.push_back(mk(CMD_TICK, 0, 0));
    rows.push_back(mk(CMD_OFF, 42, 0));
    for (int i = 0; i < 14; i++) rows.push_back(mk(CMD_ON, 60 + i, 65535));
    rows.push_back(mk(CMD_TICK, 0, 0));
    foreach (rows[i]) send(rows[i]);
    drain_and_wait();

    rates = '{21'd1, 21'd1048576, 21'h1FFFFF, 21'd0};
    for (int ph = 0; ph < 6; ph++) begin
      write_rate(ph < 4 ? rates[ph] : 21'($urandom_range(1, 1048576)));
      for (int k = 0; k < 300; k++) begin
        beat_t b;
        b = random_beat();
        send(b);
        if (k == 150) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (samples_due.size() > 0) @(posedge clk);
        end
      end
      drain_and_wait();
    end

    drain_and_wait();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/pvs_pkg.sv
rtl/core/pvs_mul.sv
rtl/core/pvs_sine_rom.sv
rtl/core/pvs_voice_ram.sv
rtl/core/poly_voice_synth.sv
bench/poly_voice_synth_test.sv
